// ===== hw/rtl/jfs_pkg.sv =====
// ----------------------------------------------------------------------------
// jfs_pkg
// types, marker codes and marker classification for the frame type scanner
// ----------------------------------------------------------------------------
package jfs_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned VerdictW = 2;

  // marker byte values
  localparam logic [ByteW-1:0] MarkPrefix = 8'hFF;
  localparam logic [ByteW-1:0] MarkSoi    = 8'hD8;
  localparam logic [ByteW-1:0] MarkTem    = 8'h01;
  localparam logic [ByteW-1:0] MarkRstLo  = 8'hD0;
  localparam logic [ByteW-1:0] MarkEoi    = 8'hD9;
  localparam logic [ByteW-1:0] MarkSos    = 8'hDA;

  typedef enum logic [2:0] {
    PH_PRE0  = 3'd0,
    PH_PRE1  = 3'd1,
    PH_SCAN  = 3'd2,
    PH_MARK  = 3'd3,
    PH_LENHI = 3'd4,
    PH_LENLO = 3'd5,
    PH_SKIP  = 3'd6,
    PH_WAIT  = 3'd7
  } phase_e;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_PROG = 2'd0,
    VERDICT_SEQ  = 2'd1,
    VERDICT_SCAN = 2'd2,
    VERDICT_END  = 2'd3
  } verdict_e;

  // kind of byte that follows an ff prefix
  typedef enum logic [2:0] {
    MK_FILL,
    MK_STANDALONE,
    MK_SOS,
    MK_SOF_PROG,
    MK_SOF_SEQ,
    MK_SEGMENT
  } marker_e;

  function automatic marker_e classify_marker(logic [ByteW-1:0] b);
    marker_e k;
    k = MK_SEGMENT;
    if (b == MarkPrefix) begin
      k = MK_FILL;
    end else if (b == MarkTem || (b >= MarkRstLo && b <= MarkEoi)) begin
      k = MK_STANDALONE;
    end else if (b == MarkSos) begin
      k = MK_SOS;
    end else if (b == 8'hC2 || b == 8'hC6 || b == 8'hCA) begin
      k = MK_SOF_PROG;
    end else if (b == 8'hC0 || b == 8'hC1 || b == 8'hC3 || b == 8'hC5 ||
                 b == 8'hC7 || b == 8'hC9 || b == 8'hCB || b == 8'hCD ||
                 b == 8'hCE || b == 8'hCF) begin
      k = MK_SOF_SEQ;
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/jfs_byte_if.sv =====
// ----------------------------------------------------------------------------
// jfs_byte_if
// byte stream channel with last-byte mark
// ----------------------------------------------------------------------------
interface jfs_byte_if;
  logic                      valid;
  logic                      ready;
  logic [jfs_pkg::ByteW-1:0] byte_value;
  logic                      last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== hw/rtl/jfs_verdict_if.sv =====
// ----------------------------------------------------------------------------
// jfs_verdict_if
// verdict channel, one item per stream
// ----------------------------------------------------------------------------
interface jfs_verdict_if;
  logic                         valid;
  logic                         ready;
  logic [jfs_pkg::VerdictW-1:0] verdict;
  logic                         is_progressive;

  modport source (output valid, output verdict, output is_progressive, input ready);
  modport sink   (input valid, input verdict, input is_progressive, output ready);
endinterface

// ===== hw/rtl/jpeg_frame_type_scanner_core.sv =====
// ----------------------------------------------------------------------------
// jpeg_frame_type_scanner_core
// scans a jpeg byte stream for its soi prefix and first decisive marker and
// gives one frame type verdict per stream
// ----------------------------------------------------------------------------
//
//   channel    dir   payload                       meaning
//   byte_i     in    byte_value[7:0], last_byte    one stream byte per item
//   verdict_o  out   verdict[1:0], is_progressive  one verdict per stream
//
// a byte is taken every cycle while byte_i.ready is high; scan state updates in
// the accepting cycle, and the verdict is registered the cycle after its byte
// byte_i.ready drops only while a verdict sits in the output register and
// verdict_o.ready is low; a waiting verdict never blocks the next byte otherwise
// reset (rst_ni low) returns the scanner to the first prefix byte and empties
// the output register; the last byte of each stream does the same for state
//
module jpeg_frame_type_scanner_core (
  input  logic clk_i,
  input  logic rst_ni,
  jfs_byte_if.sink      byte_i,
  jfs_verdict_if.source verdict_o
);
  import jfs_pkg::*;

  // scan state
  phase_e              phase_q, phase_d;
  logic [LenW-1:0]     skip_q, skip_d;      // segment bytes still to skip
  logic [ByteW-1:0]    len_hi_q, len_hi_d;  // high length byte
  verdict_e            pend_q, pend_d;      // verdict of a decisive marker
  logic                wait_q, wait_d;      // one more byte before the verdict
  logic                given_q, given_d;    // verdict already given

  // output register
  logic                out_valid_q, out_valid_d;
  verdict_e            out_verdict_q, out_verdict_d;

  logic                fire;
  logic                emit;
  verdict_e            emit_verdict;
  logic [ByteW-1:0]    b;
  logic [LenW-1:0]     seg_len;
  marker_e             mk;

  assign b        = byte_i.byte_value;
  assign mk       = classify_marker(b);
  assign seg_len  = {len_hi_q, b};
  // a new byte is taken whenever the output register is free or draining
  assign byte_i.ready = !out_valid_q || verdict_o.ready;
  assign fire     = byte_i.valid && byte_i.ready;

  // verdict decision for the current byte
  always_comb begin
    emit         = 1'b0;
    emit_verdict = VERDICT_END;
    if (!given_q) begin
      unique case (phase_q)
        PH_PRE0: emit = (b != MarkPrefix);
        PH_PRE1: emit = (b != MarkSoi);
        PH_WAIT: begin
          if (!wait_q) begin
            emit         = 1'b1;
            emit_verdict = pend_q;
          end
        end
        default: emit = 1'b0;
      endcase
      // stream ends with nothing decided
      if (!emit && byte_i.last_byte) begin
        emit         = 1'b1;
        emit_verdict = VERDICT_END;
      end
    end
  end

  // next scan state
  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    len_hi_d = len_hi_q;
    pend_d   = pend_q;
    wait_d   = wait_q;
    given_d  = given_q;
    if (fire) begin
      if (!given_q) begin
        unique case (phase_q)
          PH_PRE0: if (b == MarkPrefix) phase_d = PH_PRE1;
          PH_PRE1: if (b == MarkSoi) phase_d = PH_SCAN;
          PH_SCAN: if (b == MarkPrefix) phase_d = PH_MARK;
          PH_MARK: begin
            unique case (mk)
              MK_FILL:       phase_d = PH_MARK;
              MK_STANDALONE: phase_d = PH_SCAN;
              MK_SOS: begin
                pend_d  = VERDICT_SCAN;
                wait_d  = 1'b1;
                phase_d = PH_WAIT;
              end
              MK_SOF_PROG: begin
                pend_d  = VERDICT_PROG;
                wait_d  = 1'b1;
                phase_d = PH_WAIT;
              end
              MK_SOF_SEQ: begin
                pend_d  = VERDICT_SEQ;
                wait_d  = 1'b1;
                phase_d = PH_WAIT;
              end
              default: phase_d = PH_LENHI;
            endcase
          end
          PH_LENHI: begin
            len_hi_d = b;
            phase_d  = PH_LENLO;
          end
          PH_LENLO: begin
            // a length below two replays only zero and one bytes through the
            // scan, which never leave the scan phase
            if (len_hi_q != '0 || b >= 8'd2) begin
              skip_d  = seg_len - LenW'(2);
              phase_d = (seg_len != LenW'(2)) ? PH_SKIP : PH_SCAN;
            end else begin
              phase_d = PH_SCAN;
            end
          end
          PH_SKIP: begin
            if (skip_q <= LenW'(1)) begin
              skip_d  = '0;
              phase_d = PH_SCAN;
            end else begin
              skip_d = skip_q - LenW'(1);
            end
          end
          PH_WAIT: wait_d = 1'b0;
          default: phase_d = phase_q;
        endcase
        if (emit) given_d = 1'b1;
      end
      // each stream starts over from reset values
      if (byte_i.last_byte) begin
        phase_d  = PH_PRE0;
        skip_d   = '0;
        len_hi_d = '0;
        pend_d   = VERDICT_PROG;
        wait_d   = 1'b0;
        given_d  = 1'b0;
      end
    end
  end

  // output register load and drain
  always_comb begin
    out_valid_d   = out_valid_q;
    out_verdict_d = out_verdict_q;
    if (fire && emit) begin
      out_valid_d   = 1'b1;
      out_verdict_d = emit_verdict;
    end else if (verdict_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PRE0;
      skip_q      <= '0;
      len_hi_q    <= '0;
      pend_q      <= VERDICT_PROG;
      wait_q      <= 1'b0;
      given_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      len_hi_q    <= len_hi_d;
      pend_q      <= pend_d;
      wait_q      <= wait_d;
      given_q     <= given_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_verdict_q <= out_verdict_d;
  end

  assign verdict_o.valid          = out_valid_q;
  assign verdict_o.verdict        = out_verdict_q;
  assign verdict_o.is_progressive = (out_verdict_q == VERDICT_PROG);

endmodule
